@@ sv/ihb_pkg.sv @@
// Shared types and constants of the Ising heat-bath site update block.
// No dependencies; every other file refers to it by scoped names.
package ihb_pkg;

  // Lattice geometry: SideBits per coordinate, row-major site address.
  localparam int unsigned SideBits = 7;
  localparam int unsigned AddrBits = 2 * SideBits;
  localparam int unsigned Depth    = 1 << AddrBits;

  // Threshold registers.
  localparam int unsigned NumRegs   = 5;
  localparam int unsigned ProbBits  = 17;
  localparam int unsigned RegIdxBits = 3;
  localparam int unsigned PaddrBits = 5;
  localparam int unsigned DataBits  = 32;
  localparam logic [ProbBits-1:0] ProbReset = 17'd32768;

  // Operation codes; the unused code behaves as a read.
  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpUpdate = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  typedef logic [SideBits-1:0] coord_t;
  typedef logic [AddrBits-1:0] site_addr_t;
  typedef logic [NumRegs-1:0][ProbBits-1:0] prob_array_t;

  // Request to the single-port lattice RAM.
  typedef struct packed {
    logic       we;
    logic       re;
    site_addr_t addr;
    logic       wdata;
  } mem_req_t;

endpackage

@@ sv/ihb_spin_ram.sv @@
// Single-port one-bit lattice RAM with registered read data.
// Depends on ihb_pkg for the request type and depth.
module ihb_spin_ram (
  input  logic             clk_i,
  input  ihb_pkg::mem_req_t req_i,
  output logic             rdata_o
);

  logic mem_q [ihb_pkg::Depth];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ihb_regs.sv @@
// APB-style register file holding the five heat-bath thresholds.
// Depends on ihb_pkg for widths, reset value and the threshold array type.
module ihb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ihb_pkg::PaddrBits-1:0]   paddr,
  input  logic [ihb_pkg::DataBits-1:0]    pwdata,
  output logic [ihb_pkg::DataBits-1:0]    prdata,
  output logic                            pready,
  output ihb_pkg::prob_array_t            prob_o
);

  ihb_pkg::prob_array_t prob_q;
  logic [ihb_pkg::RegIdxBits-1:0] idx;
  logic wr_en;

  assign idx   = paddr[ihb_pkg::PaddrBits-1:2];
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ihb_pkg::NumRegs; i++) begin
        prob_q[i] <= ihb_pkg::ProbReset;
      end
    end else if (wr_en && (idx < ihb_pkg::RegIdxBits'(ihb_pkg::NumRegs))) begin
      prob_q[idx] <= pwdata[ihb_pkg::ProbBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < ihb_pkg::RegIdxBits'(ihb_pkg::NumRegs)) begin
      prdata = ihb_pkg::DataBits'(prob_q[idx]);
    end
  end

  assign pready = 1'b1;
  assign prob_o = prob_q;

endmodule

@@ sv/ising_heat_bath_site_update.sv @@
// Heat-bath site update on a 128 x 128 periodic one-bit Ising lattice.
// Sequence per operation: write WRITE, DONE; read READ, READ_CAP, DONE; update NBR,
// NBR_LAST, DECIDE, DONE. A new transaction is accepted only in idle, so the single-port
// RAM (one access per cycle) and the result hand-off bound the throughput.
// Reset clears the sequencer and output valid and sets every threshold to one half;
// the lattice holds no reset value and is loaded by writes. A held result stalls input.
module ising_heat_bath_site_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [6:0]                    row_i,
  input  logic [6:0]                    column_i,
  input  logic                          spin_in_i,
  input  logic [15:0]                   random_draw_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          spin_out_o,
  output logic signed [3:0]             neighbor_sum_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ihb_pkg::PaddrBits-1:0] paddr,
  input  logic [ihb_pkg::DataBits-1:0]  pwdata,
  output logic [ihb_pkg::DataBits-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE,      // wait for a transaction
    ST_WRITE,     // write the site
    ST_READ,      // issue the site read
    ST_READ_CAP,  // capture the read data
    ST_NBR,       // issue neighbor reads, accumulate the previous one
    ST_NBR_LAST,  // accumulate the fourth neighbor
    ST_DECIDE,    // compare draw against threshold, write the site
    ST_DONE       // hand the result to the output register
  } state_e;

  state_e state_q;

  // Captured transaction
  ihb_pkg::coord_t row_q;
  ihb_pkg::coord_t col_q;
  logic            spin_q;
  logic [15:0]     draw_q;

  // Sequencer datapath
  logic [1:0] cnt_q;   // neighbor index: up, down, left, right
  logic [2:0] ups_q;   // count of +1 neighbors, 0..4
  logic       res_spin_q;
  logic [3:0] res_sum_q;

  // Output register
  logic       out_valid_q;
  logic       out_spin_q;
  logic [3:0] out_sum_q;

  ihb_pkg::prob_array_t prob;
  ihb_pkg::mem_req_t    mem_req;
  logic                 mem_rdata;

  ihb_pkg::site_addr_t  site_addr;
  ihb_pkg::site_addr_t  nbr_addr;
  ihb_pkg::coord_t      nbr_base;
  ihb_pkg::coord_t      nbr_coord;
  logic                 new_spin;
  logic                 out_free;
  logic                 accept;

  ihb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .prob_o  (prob)
  );

  ihb_spin_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  assign site_addr = {row_q, col_q};

  // Neighbor address: one shared 7-bit adder steps either the row or the
  // column by -1 or +1 and wraps naturally at the lattice edge.
  //   cnt 0: row - 1, cnt 1: row + 1, cnt 2: column - 1, cnt 3: column + 1
  assign nbr_base  = cnt_q[1] ? col_q : row_q;
  assign nbr_coord = nbr_base + (cnt_q[0] ? ihb_pkg::coord_t'(1) : '1);
  assign nbr_addr  = cnt_q[1] ? {row_q, nbr_coord} : {nbr_coord, col_q};

  // Heat bath: go to -1 when the draw falls below the threshold picked by
  // the up-neighbor count; a threshold of 65536 or above always flips down.
  assign new_spin = ({1'b0, draw_q} < prob[ups_q]) ? 1'b0 : 1'b1;

  // Drive the RAM from the sequencer state.
  always_comb begin
    mem_req       = '0;
    mem_req.addr  = site_addr;
    mem_req.wdata = spin_q;
    case (state_q)
      ST_WRITE: begin
        mem_req.we = 1'b1;
      end
      ST_READ: begin
        mem_req.re = 1'b1;
      end
      ST_NBR: begin
        mem_req.re   = 1'b1;
        mem_req.addr = nbr_addr;
      end
      ST_DECIDE: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = new_spin;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      spin_q      <= 1'b0;
      draw_q      <= '0;
      cnt_q       <= '0;
      ups_q       <= '0;
      res_spin_q  <= 1'b0;
      res_sum_q   <= '0;
      out_valid_q <= 1'b0;
      out_spin_q  <= 1'b0;
      out_sum_q   <= '0;
    end else begin
      // Drop the output once the consumer takes it.
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            row_q  <= row_i;
            col_q  <= column_i;
            spin_q <= spin_in_i;
            draw_q <= random_draw_i;
            cnt_q  <= '0;
            ups_q  <= '0;
            if (operation_i == ihb_pkg::OpWrite) begin
              state_q <= ST_WRITE;
            end else if (operation_i == ihb_pkg::OpUpdate) begin
              state_q <= ST_NBR;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_WRITE: begin
          res_spin_q <= spin_q;
          res_sum_q  <= '0;
          state_q    <= ST_DONE;
        end
        ST_READ: begin
          state_q <= ST_READ_CAP;
        end
        ST_READ_CAP: begin
          res_spin_q <= mem_rdata;
          res_sum_q  <= '0;
          state_q    <= ST_DONE;
        end
        ST_NBR: begin
          // Read data is registered, so it arrives in the cycle after its address: fold in the previous
          // neighbor while issuing the next.
          if (cnt_q != 2'd0) begin
            ups_q <= ups_q + 3'(mem_rdata);
          end
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= ST_NBR_LAST;
          end
        end
        ST_NBR_LAST: begin
          ups_q   <= ups_q + 3'(mem_rdata);
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          // Neighbor sum is 2 * ups - 4 in four-bit two's complement.
          res_spin_q <= new_spin;
          res_sum_q  <= {ups_q, 1'b0} - 4'd4;
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_spin_q  <= res_spin_q;
            out_sum_q   <= res_sum_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign spin_out_o     = out_spin_q;
  assign neighbor_sum_o = $signed(out_sum_q);

endmodule
